@@ sv/dtrt_pkg.sv @@
// Shared types, codes and the sequencer control store of the dirty tile refresh tracker.
`timescale 1ns / 1ps

package dtrt_pkg;

    localparam logic [1:0] KIND_UPDATE  = 2'd0;
    localparam logic [1:0] KIND_SERVICE = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ENABLED      = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SWEEP,
        OP_ACCEPT,
        OP_SETUP,
        OP_VREAD,
        OP_VCHECK,
        OP_POP_READ,
        OP_POP,
        OP_RESULT
    } op_t;

    typedef enum logic [3:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_SWEEP_MORE,
        J_RESTART,
        J_NO_RANGE,
        J_TILE_MORE,
        J_FIFO_EMPTY,
        J_WAIT_OUT
    } jmp_t;

    typedef logic [3:0] pc_t;

    localparam pc_t P_CLEAR       = 4'd0;
    localparam pc_t P_AFTER_CLEAR = 4'd1;
    localparam pc_t P_IDLE        = 4'd2;
    localparam pc_t P_SETUP       = 4'd3;
    localparam pc_t P_READ        = 4'd4;
    localparam pc_t P_CHECK       = 4'd5;
    localparam pc_t P_DONE        = 4'd6;
    localparam pc_t P_POP_READ    = 4'd7;
    localparam pc_t P_POP         = 4'd8;

    typedef struct packed {
        op_t  op;
        jmp_t jmp;
        pc_t  target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        case (pc)
            P_CLEAR:       w = '{op: OP_SWEEP,    jmp: J_SWEEP_MORE, target: P_CLEAR};
            P_AFTER_CLEAR: w = '{op: OP_NONE,     jmp: J_RESTART,    target: P_SETUP};
            P_IDLE:        w = '{op: OP_ACCEPT,   jmp: J_DISPATCH,   target: P_IDLE};
            P_SETUP:       w = '{op: OP_SETUP,    jmp: J_NO_RANGE,   target: P_DONE};
            P_READ:        w = '{op: OP_VREAD,    jmp: J_NEXT,       target: P_CHECK};
            P_CHECK:       w = '{op: OP_VCHECK,   jmp: J_TILE_MORE,  target: P_READ};
            P_DONE:        w = '{op: OP_RESULT,   jmp: J_WAIT_OUT,   target: P_IDLE};
            P_POP_READ:    w = '{op: OP_POP_READ, jmp: J_FIFO_EMPTY, target: P_DONE};
            P_POP:         w = '{op: OP_POP,      jmp: J_GOTO,       target: P_DONE};
            default:       w = '{op: OP_NONE,     jmp: J_GOTO,       target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ sv/dtrt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module dtrt_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dirty_tile_refresh_tracker.sv @@
// Top level of the dirty tile refresh tracker: microcoded sequencer, tile valid RAM and refresh FIFO.
// The image is cut into square tiles 2^TILE_SHIFT pixels on a side with one valid bit each, held in a
// RAM of MAX_COLS*MAX_ROWS entries; queued tiles sit in a FIFO RAM of the same depth. A short
// program in a control store steps through each item, and every item gives exactly one result.
// After reset a clearing pass sets every valid bit, one entry per cycle, so the block takes no
// item until that pass is done. An update item sets up its clipped tile range and then visits
// each tile in it with one RAM read and one conditional write and push. A service item reads
// the queue head and pops it unless the queue is empty, and an item of unknown kind goes
// straight to its result step. A restart item empties the queue, runs a clearing pass and then
// treats the whole image as an update. A finished result waits in the output register while the
// next item is taken; the result step of that next item holds until the receiver has taken the
// waiting one.
`timescale 1ns / 1ps

module dirty_tile_refresh_tracker
    import dtrt_pkg::*;
#(
    parameter int TILE_SHIFT = 8,
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // rect_x, rect_y, rect_width, rect_height, zero pad
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tile_refreshed, tile_col, tile_row, queue_empty, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int NUM_TILES = MAX_COLS * MAX_ROWS;
    localparam int IW        = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
    localparam int CNTW      = $clog2(NUM_TILES + 1);
    localparam int CW        = $clog2(MAX_COLS + 1);
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int CIW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FW        = CIW + RIW;
    localparam int PW        = (((CW + TILE_SHIFT) > 17) ? (CW + TILE_SHIFT) : 17) + 1;

    localparam logic signed [PW-1:0] TSZ        = PW'(1 << TILE_SHIFT);
    localparam logic        [14:0]   TILE_ROUND = 15'((1 << TILE_SHIFT) - 1);
    localparam logic        [IW-1:0] LAST_TILE  = IW'(NUM_TILES - 1);
    localparam logic      [CNTW-1:0] CNT_FULL   = CNTW'(NUM_TILES);
    localparam logic        [CW-1:0] COLS_MAX   = CW'(MAX_COLS);
    localparam logic        [RW-1:0] ROWS_MAX   = RW'(MAX_ROWS);

    pc_t   pc_reg, pc_next;
    ctrl_t ctrl;

    logic [13:0] img_w_reg, img_w_next;
    logic [13:0] img_h_reg, img_h_next;
    logic        en_reg, en_next;
    logic        restart_reg, restart_next;
    logic [IW-1:0]   sweep_reg, sweep_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [14:0] rx_reg, rx_next;
    logic signed [14:0] ry_reg, ry_next;
    logic [14:0] rw_reg, rw_next;
    logic [14:0] rh_reg, rh_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] c1_reg, c1_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] r0_reg, r0_next;
    logic [RW-1:0] r1_reg, r1_next;
    logic        res_ref_reg, res_ref_next;
    logic [4:0]  res_col_reg, res_col_next;
    logic [4:0]  res_row_reg, res_row_next;
    logic [15:0] out_data_reg, out_data_next;

    logic [14:0] cols_raw, rows_raw;
    logic [CW-1:0] cols, c0, c1;
    logic [RW-1:0] rows, r0, r1;
    logic signed [PW-1:0] xlim, ylim, x0, y0, x1, y1, x1c, y1c;
    logic range_empty;

    logic [IW-1:0] tile_idx, pop_idx;
    logic [CW-1:0] c_inc;
    logic [RW-1:0] r_inc;
    logic r_last, c_last, tile_more, out_free;

    logic          vram_we, vram_wdata, vram_re, vram_rdata;
    logic [IW-1:0] vram_waddr;
    logic          fram_we, fram_re;
    logic [FW-1:0] fram_wdata, fram_rdata;
    logic [CIW-1:0] pop_col;
    logic [RIW-1:0] pop_row;

    dtrt_ram #(
        .DATA_W (1),
        .DEPTH  (NUM_TILES),
        .ADDR_W (IW)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (tile_idx),
        .rdata (vram_rdata)
    );

    dtrt_ram #(
        .DATA_W (FW),
        .DEPTH  (NUM_TILES),
        .ADDR_W (IW)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (tail_reg),
        .wdata (fram_wdata),
        .re    (fram_re),
        .raddr (head_reg),
        .rdata (fram_rdata)
    );

    assign ctrl      = ucode_rom(pc_reg);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Rectangle clipping and conversion to a tile range.
    always_comb
    begin
        cols_raw = (15'(img_w_reg) + TILE_ROUND) >> TILE_SHIFT;
        rows_raw = (15'(img_h_reg) + TILE_ROUND) >> TILE_SHIFT;
        cols = (cols_raw > 15'(MAX_COLS)) ? COLS_MAX : CW'(cols_raw);
        rows = (rows_raw > 15'(MAX_ROWS)) ? ROWS_MAX : RW'(rows_raw);
        xlim = PW'(cols) << TILE_SHIFT;
        ylim = PW'(rows) << TILE_SHIFT;
        x0   = rx_reg[14] ? '0 : PW'(rx_reg);
        y0   = ry_reg[14] ? '0 : PW'(ry_reg);
        x1   = PW'(rx_reg) + PW'($signed({1'b0, rw_reg}));
        y1   = PW'(ry_reg) + PW'($signed({1'b0, rh_reg}));
        x1c  = (x1 > xlim) ? xlim : x1;
        y1c  = (y1 > ylim) ? ylim : y1;
        range_empty = !en_reg || (x1c <= x0) || (y1c <= y0);
        c0 = CW'(x0 >>> TILE_SHIFT);
        r0 = RW'(y0 >>> TILE_SHIFT);
        c1 = CW'((x1c + TSZ - PW'(1)) >>> TILE_SHIFT);
        r1 = RW'((y1c + TSZ - PW'(1)) >>> TILE_SHIFT);
    end

    always_comb
    begin
        tile_idx  = IW'(IW'(c_reg) * IW'(MAX_ROWS) + IW'(r_reg));
        pop_col   = fram_rdata[FW-1:RIW];
        pop_row   = fram_rdata[RIW-1:0];
        pop_idx   = IW'(IW'(pop_col) * IW'(MAX_ROWS) + IW'(pop_row));
        c_inc     = CW'(c_reg + 1'b1);
        r_inc     = RW'(r_reg + 1'b1);
        r_last    = (r_inc == r1_reg);
        c_last    = (c_inc == c1_reg);
        tile_more = !(r_last && c_last);
    end

    // Sequencer: next step from the jump field of the control word.
    always_comb
    begin
        case (ctrl.jmp)
            J_NEXT:
            begin
                pc_next = pc_t'(pc_reg + 1'b1);
            end
            J_GOTO:
            begin
                pc_next = ctrl.target;
            end
            J_DISPATCH:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        KIND_UPDATE:  pc_next = P_SETUP;
                        KIND_SERVICE: pc_next = P_POP_READ;
                        KIND_RESTART: pc_next = P_CLEAR;
                        default:      pc_next = P_DONE;
                    endcase
                end
                else
                begin
                    pc_next = ctrl.target;
                end
            end
            J_SWEEP_MORE:
            begin
                pc_next = (sweep_reg != LAST_TILE) ? ctrl.target : pc_t'(pc_reg + 1'b1);
            end
            J_RESTART:
            begin
                pc_next = restart_reg ? ctrl.target : pc_t'(pc_reg + 1'b1);
            end
            J_NO_RANGE:
            begin
                pc_next = range_empty ? ctrl.target : pc_t'(pc_reg + 1'b1);
            end
            J_TILE_MORE:
            begin
                pc_next = tile_more ? ctrl.target : pc_t'(pc_reg + 1'b1);
            end
            J_FIFO_EMPTY:
            begin
                pc_next = (cnt_reg == '0) ? ctrl.target : pc_t'(pc_reg + 1'b1);
            end
            J_WAIT_OUT:
            begin
                pc_next = out_free ? ctrl.target : pc_reg;
            end
            default:
            begin
                pc_next = P_IDLE;
            end
        endcase
    end

    // Datapath driven by the operation field of the control word.
    always_comb
    begin
        img_w_next     = img_w_reg;
        img_h_next     = img_h_reg;
        en_next        = en_reg;
        restart_next   = restart_reg;
        sweep_next     = sweep_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        c_next         = c_reg;
        c1_next        = c1_reg;
        r_next         = r_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        res_ref_next   = res_ref_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        out_data_next  = out_data_reg;
        s_axis_tready  = 1'b0;
        vram_we        = 1'b0;
        vram_waddr     = tile_idx;
        vram_wdata     = 1'b0;
        vram_re        = 1'b0;
        fram_we        = 1'b0;
        fram_wdata     = {CIW'(c_reg), RIW'(r_reg)};
        fram_re        = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_next = cfg_data;
                CFG_IMAGE_HEIGHT: img_h_next = cfg_data;
                CFG_ENABLED:      en_next    = cfg_data[0];
                default:          ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.op)
            OP_SWEEP:
            begin
                vram_we    = 1'b1;
                vram_waddr = sweep_reg;
                vram_wdata = 1'b1;
                sweep_next = (sweep_reg == LAST_TILE) ? '0 : IW'(sweep_reg + 1'b1);
            end
            OP_ACCEPT:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    res_ref_next = 1'b0;
                    res_col_next = '0;
                    res_row_next = '0;
                    rx_next      = s_axis_tdata[14:0];
                    ry_next      = s_axis_tdata[29:15];
                    rw_next      = s_axis_tdata[44:30];
                    rh_next      = s_axis_tdata[59:45];
                    if (s_axis_tuser == KIND_RESTART)
                    begin
                        head_next    = '0;
                        tail_next    = '0;
                        cnt_next     = '0;
                        restart_next = 1'b1;
                        rx_next      = '0;
                        ry_next      = '0;
                        rw_next      = 15'(img_w_reg);
                        rh_next      = 15'(img_h_reg);
                    end
                end
            end
            OP_SETUP:
            begin
                restart_next = 1'b0;
                c_next       = c0;
                c1_next      = c1;
                r_next       = r0;
                r0_next      = r0;
                r1_next      = r1;
            end
            OP_VREAD:
            begin
                vram_re = 1'b1;
            end
            OP_VCHECK:
            begin
                if (vram_rdata)
                begin
                    vram_we = 1'b1;
                    if (cnt_reg < CNT_FULL)
                    begin
                        fram_we   = 1'b1;
                        tail_next = (tail_reg == LAST_TILE) ? '0 : IW'(tail_reg + 1'b1);
                        cnt_next  = CNTW'(cnt_reg + 1'b1);
                    end
                end
                if (r_last)
                begin
                    r_next = r0_reg;
                    c_next = c_inc;
                end
                else
                begin
                    r_next = r_inc;
                end
            end
            OP_POP_READ:
            begin
                fram_re = 1'b1;
            end
            OP_POP:
            begin
                head_next    = (head_reg == LAST_TILE) ? '0 : IW'(head_reg + 1'b1);
                cnt_next     = CNTW'(cnt_reg - 1'b1);
                vram_we      = 1'b1;
                vram_waddr   = pop_idx;
                vram_wdata   = 1'b1;
                res_ref_next = 1'b1;
                res_col_next = 5'(pop_col);
                res_row_next = 5'(pop_row);
            end
            OP_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, (cnt_reg == '0), res_row_reg, res_col_reg,
                                      res_ref_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= P_CLEAR;
            img_w_reg     <= '0;
            img_h_reg     <= '0;
            en_reg        <= 1'b0;
            restart_reg   <= 1'b0;
            sweep_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            img_w_reg     <= img_w_next;
            img_h_reg     <= img_h_next;
            en_reg        <= en_next;
            restart_reg   <= restart_next;
            sweep_reg     <= sweep_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        rw_reg       <= rw_next;
        rh_reg       <= rh_next;
        c_reg        <= c_next;
        c1_reg       <= c1_next;
        r_reg        <= r_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        res_ref_reg  <= res_ref_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        out_data_reg <= out_data_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("refresh queue count above its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_POP) |-> (cnt_reg != '0))
        else $error("pop from an empty refresh queue");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_RESULT))
        else $error("result shown without a result step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (pc_reg != P_IDLE))
        else $error("accepted item was not dispatched");

endmodule

@@ dv/tb_dirty_tile_refresh_tracker.sv @@
// Self-checking testbench for the dirty tile refresh tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_dirty_tile_refresh_tracker;
    import dtrt_pkg::*;

    localparam int TILE_SHIFT  = 8;
    localparam int MAX_COLS    = 32;
    localparam int MAX_ROWS    = 32;
    localparam int NUM_TILES   = MAX_COLS * MAX_ROWS;
    localparam int TILE_PX     = 1 << TILE_SHIFT;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int PLAN_LEN    = 27;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic       qempty;
        logic [4:0] row;
        logic [4:0] col;
        logic       refreshed;
    } tile_res_t;

    // For register rows a, b and c carry width, height and enable.
    typedef struct packed {
        bit         is_cfg;
        logic [1:0] kind;
        int         a;
        int         b;
        int         c;
        int         d;
        bit         known;
        tile_res_t  want;
    } step_t;

    localparam tile_res_t RES_IDLE = '{qempty: 1'b1, row: 5'd0, col: 5'd0, refreshed: 1'b0};
    localparam tile_res_t RES_BUSY = '{qempty: 1'b0, row: 5'd0, col: 5'd0, refreshed: 1'b0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // rect_x, rect_y, rect_width, rect_height, zero pad
    logic [1:0]  s_axis_tuser = KIND_UPDATE;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // tile_refreshed, tile_col, tile_row, queue_empty, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [13:0] cfg_data = '0;

    // Typed expectation that travels beside the offered item.
    bit          typed_ok = 1'b0;
    tile_res_t   typed_res = RES_IDLE;

    // Mirror of the block: registers, tile valid bits and refresh queue.
    logic [13:0] img_w = '0;
    logic [13:0] img_h = '0;
    logic        img_en = 1'b0;
    bit          tile_ok [NUM_TILES] = '{default: 1'b1};
    logic [9:0]  refresh_q [$];

    tile_res_t   tile_expect_q [$];
    tile_res_t   want_now;
    tile_res_t   got_now;

    int errors = 0;
    int n_items = 0;
    int n_popped = 0;
    int n_restarts = 0;
    int n_settings = 0;
    int quiet = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;

    step_t plan [PLAN_LEN] = '{
        '{1'b0, KIND_UPDATE, 0, 0, 100, 100, 1'b1, RES_IDLE},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b1, RES_IDLE},
        '{1'b0, KIND_UNUSED, -1, -1, 32767, 32767, 1'b1, RES_IDLE},
        '{1'b1, KIND_UPDATE, 600, 300, 1, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, -16384, -16384, 32767, 32767, 1'b1, RES_BUSY},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b1,
          '{qempty: 1'b0, row: 5'd0, col: 5'd0, refreshed: 1'b1}},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b1,
          '{qempty: 1'b0, row: 5'd1, col: 5'd0, refreshed: 1'b1}},
        '{1'b0, KIND_UPDATE, 0, 0, 1, 1, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 16383, 16383, 32767, 32767, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 10, 10, 0, 50, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 599, 299, 1, 1, 1'b0, RES_IDLE},
        '{1'b0, KIND_RESTART, 0, 0, 0, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b0, RES_IDLE},
        '{1'b1, KIND_UPDATE, 600, 300, 0, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 0, 0, 600, 300, 1'b0, RES_IDLE},
        '{1'b0, KIND_RESTART, 0, 0, 0, 0, 1'b1, RES_IDLE},
        '{1'b1, KIND_UPDATE, 16383, 16383, 1, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 8191, 8191, 1, 1, 1'b1, RES_BUSY},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b1,
          '{qempty: 1'b1, row: 5'd31, col: 5'd31, refreshed: 1'b1}},
        '{1'b0, KIND_UPDATE, 255, 256, 2, 1, 1'b0, RES_IDLE},
        '{1'b0, KIND_UNUSED, 0, 0, 0, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, 0, 0, 16384, 16384, 1'b0, RES_IDLE},
        '{1'b0, KIND_UPDATE, -100, -100, 500, 500, 1'b0, RES_IDLE},
        '{1'b1, KIND_UPDATE, 256, 256, 1, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_RESTART, 0, 0, 0, 0, 1'b0, RES_IDLE},
        '{1'b0, KIND_SERVICE, 0, 0, 0, 0, 1'b1,
          '{qempty: 1'b1, row: 5'd0, col: 5'd0, refreshed: 1'b1}}
    };

    dirty_tile_refresh_tracker #(
        .TILE_SHIFT(TILE_SHIFT),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int tiles_across(logic [13:0] px, int lim);
        int n;
        n = (int'(px) + TILE_PX - 1) >> TILE_SHIFT;
        return (n > lim) ? lim : n;
    endfunction

    function automatic void dirty_rect(int rx, int ry, int rw, int rh);
        int cols, rows, x0, y0, x1, y1, c0, c1, r0, r1;
        logic [9:0] idx;
        cols = tiles_across(img_w, MAX_COLS);
        rows = tiles_across(img_h, MAX_ROWS);
        if (!img_en || rw <= 0 || rh <= 0 || cols <= 0 || rows <= 0)
            return;
        x0 = (rx > 0) ? rx : 0;
        y0 = (ry > 0) ? ry : 0;
        x1 = rx + rw;
        y1 = ry + rh;
        if (x1 > cols * TILE_PX)
            x1 = cols * TILE_PX;
        if (y1 > rows * TILE_PX)
            y1 = rows * TILE_PX;
        if (x1 <= x0 || y1 <= y0)
            return;
        c0 = x0 >> TILE_SHIFT;
        r0 = y0 >> TILE_SHIFT;
        c1 = (x1 + TILE_PX - 1) >> TILE_SHIFT;
        r1 = (y1 + TILE_PX - 1) >> TILE_SHIFT;
        for (int c = c0; c < c1; c++)
        begin
            for (int r = r0; r < r1; r++)
            begin
                idx = 10'(c * MAX_ROWS + r);
                if (tile_ok[idx])
                begin
                    tile_ok[idx] = 1'b0;
                    if (refresh_q.size() < NUM_TILES)
                        refresh_q.insert(refresh_q.size(), idx);
                end
            end
        end
    endfunction

    function automatic tile_res_t refresh_outcome(logic [1:0] kind, logic [63:0] d);
        tile_res_t res;
        logic [9:0] idx;
        res = RES_IDLE;
        case (kind)
            KIND_UPDATE:
                dirty_rect(int'($signed(d[14:0])), int'($signed(d[29:15])),
                           int'(d[44:30]), int'(d[59:45]));
            KIND_SERVICE:
                if (refresh_q.size() > 0)
                begin
                    idx = refresh_q[0];
                    refresh_q.delete(0);
                    tile_ok[idx] = 1'b1;
                    res.refreshed = 1'b1;
                    res.col = 5'(idx / MAX_ROWS);
                    res.row = 5'(idx % MAX_ROWS);
                end
            KIND_RESTART:
            begin
                refresh_q.delete();
                foreach (tile_ok[i])
                    tile_ok[i] = 1'b1;
                dirty_rect(0, 0, int'(img_w), int'(img_h));
            end
            default: ;
        endcase
        res.qempty = (refresh_q.size() == 0);
        return res;
    endfunction

    function automatic logic [63:0] pack_rect(int x, int y, int w, int h);
        return {4'b0, h[14:0], w[14:0], y[14:0], x[14:0]};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_now = tile_res_t'(m_axis_tdata[11:0]);
                if (tile_expect_q.size() == 0)
                begin
                    $error("result 0x%h arrived with no item outstanding", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want_now = tile_expect_q[0];
                    tile_expect_q.delete(0);
                    if (got_now.refreshed !== want_now.refreshed)
                    begin
                        $error("tile_refreshed: expected %0d, got %0d",
                               want_now.refreshed, got_now.refreshed);
                        errors++;
                    end
                    if (got_now.col !== want_now.col)
                    begin
                        $error("tile_col: expected %0d, got %0d", want_now.col, got_now.col);
                        errors++;
                    end
                    if (got_now.row !== want_now.row)
                    begin
                        $error("tile_row: expected %0d, got %0d", want_now.row, got_now.row);
                        errors++;
                    end
                    if (got_now.qempty !== want_now.qempty)
                    begin
                        $error("queue_empty: expected %0d, got %0d",
                               want_now.qempty, got_now.qempty);
                        errors++;
                    end
                    if (want_now.refreshed)
                        n_popped++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want_now = refresh_outcome(s_axis_tuser, s_axis_tdata);
                if (typed_ok)
                    want_now = typed_res;
                tile_expect_q.insert(tile_expect_q.size(), want_now);
                n_items++;
                if (s_axis_tuser == KIND_RESTART)
                    n_restarts++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  img_w = cfg_data;
                    CFG_IMAGE_HEIGHT: img_h = cfg_data;
                    CFG_ENABLED:      img_en = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d cycles with no handshake", quiet);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // The receiver takes long hold-off requests from the stimulus and otherwise stalls at random.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [63:0] d, bit known, tile_res_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= d;
        typed_ok <= known;
        typed_res <= r;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tile_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(int w, int h, int en);
        logic [1:0]  idx [3];
        logic [13:0] val [3];
        idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_ENABLED};
        val = '{w[13:0], h[13:0], {13'b0, en[0]}};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_item(output logic [1:0] kind, output logic [63:0] d);
        int pick, x, y, w, h;
        pick = $urandom_range(0, 99);
        x = int'($urandom_range(0, int'(img_w))) - int'($urandom_range(0, 300));
        y = int'($urandom_range(0, int'(img_h))) - int'($urandom_range(0, 300));
        w = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 1000);
        h = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 1000);
        if ($urandom_range(0, 39) == 0)
            w = 0;
        if ($urandom_range(0, 39) == 0)
            h = 0;
        d = {$urandom, $urandom};
        d[63:60] = 4'b0;
        if (pick < 44)
        begin
            kind = KIND_UPDATE;
            d = pack_rect(x, y, w, h);
        end
        else if (pick < 88)
            kind = KIND_SERVICE;
        else if (pick < 91)
            kind = KIND_RESTART;
        else if (pick < 94)
            kind = KIND_UNUSED;
        else
            kind = KIND_UPDATE;
    endtask

    task automatic run_phase(int items, int w, int h, int en, int idle, int stall, bit squeeze);
        logic [1:0]  kind;
        logic [63:0] d;
        configure(w, h, en);
        send_idle_pct = idle;
        stall_pct = stall;
        if (squeeze)
            hold_requests = hold_requests + 1;
        for (int i = 0; i < items; i++)
        begin
            random_item(kind, d);
            send_item(kind, d, 1'b0, RES_IDLE);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                configure(plan[i].a, plan[i].b, plan[i].c);
            end
            else
                send_item(plan[i].kind, pack_rect(plan[i].a, plan[i].b, plan[i].c, plan[i].d),
                          plan[i].known, plan[i].want);
        end
        wait_drained();

        run_phase(300, 8192, 8192, 1, 0, 0, 1'b0);
        run_phase(300, 16383, 16383, 1, 56, 0, 1'b0);
        run_phase(300, 1000, 700, 1, 0, 56, 1'b1);
        run_phase(250, 1, 1, 1, 19, 19, 1'b0);
        run_phase(100, 8192, 257, 0, 0, 0, 1'b0);
        run_phase(300, $urandom_range(0, 16383), $urandom_range(0, 16383), 1, 19, 19, 1'b0);

        repeat (200) @(posedge clk);
        $display("Covered %0d items under %0d register settings: %0d tiles refreshed, %0d restarts,",
                 n_items, n_settings, n_popped, n_restarts);
        $display("with free-running, sender-idle, receiver-stall and mixed flow control.");
        if (errors == 0 && tile_expect_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
